[rtl/zcpm_pkg.sv]
// ----------------------------------------------------------------------------
// zcpm_pkg
// Shared widths, codes and types of the zero crossing period meter.
// ----------------------------------------------------------------------------
package zcpm_pkg;

    localparam int MAX_PERIODS_DEF   = 256;
    localparam int STABLE_WINDOW_DEF = 5;

    localparam int REQ_W      = 2;
    localparam int SAMPLE_W   = 16;
    localparam int PERIOD_W   = 48;
    localparam int TOTAL_W    = 56;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 9;
    localparam int CFG_W      = 8;
    localparam int FRAC_W     = 16;
    localparam int INDEX_W    = 32;
    localparam int POS_W      = INDEX_W + 1 + FRAC_W;
    localparam int DEN_W      = SAMPLE_W + 1;
    localparam int QUO_W      = FRAC_W + 1;
    localparam int REM_W      = DEN_W + 1;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_START  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STOP   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_IDLE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SETTLING = 3'd1;
    localparam logic [STATUS_W-1:0] ST_STABLE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DONE     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FAILED   = 3'd4;

    localparam logic [CFG_W-1:0] NPS_RESET = 8'd10;
    localparam logic [APB_ADDR_W-3:0] REG_NPS = '0;

    localparam logic signed [POS_W-1:0] POS_START =
        {{(POS_W-FRAC_W){1'b1}}, {FRAC_W{1'b0}}};

    typedef struct packed {
        logic clear;
        logic push;
        logic check;
    } win_ctrl_t;

    typedef struct packed {
        logic done;
        logic stable;
    } win_stat_t;

endpackage

[rtl/zcpm_in_if.sv]
// ----------------------------------------------------------------------------
// zcpm_in_if
// Request channel: audio samples, start and stop requests.
// ----------------------------------------------------------------------------
interface zcpm_in_if;
    import zcpm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [REQ_W-1:0]           req_type;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, req_type, sample, input ready);
    modport sink (input valid, req_type, sample, output ready);
endinterface

[rtl/zcpm_out_if.sv]
// ----------------------------------------------------------------------------
// zcpm_out_if
// Result channel: crossing, period and measurement status.
// ----------------------------------------------------------------------------
interface zcpm_out_if;
    import zcpm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  crossing;
    logic [PERIOD_W-1:0]   period;
    logic                  period_counts;
    logic [STATUS_W-1:0]   status;
    logic [COUNT_W-1:0]    valid_count;
    logic [TOTAL_W-1:0]    period_total;

    modport source (output valid, crossing, period, period_counts, status,
                    valid_count, period_total, input ready);
    modport sink (input valid, crossing, period, period_counts, status,
                  valid_count, period_total, output ready);
endinterface

[rtl/zcpm_cfg.sv]
// ----------------------------------------------------------------------------
// zcpm_cfg
// APB register file holding the number of valid periods to collect.
// ----------------------------------------------------------------------------
module zcpm_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [zcpm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [zcpm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [zcpm_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output logic [zcpm_pkg::CFG_W-1:0]      num_period_samples
);
    import zcpm_pkg::*;

    logic [CFG_W-1:0] nps_reg;
    logic             hit;

    assign hit    = (paddr[APB_ADDR_W-1:2] == REG_NPS);
    assign pready = 1'b1;
    assign prdata = hit ? {{(APB_DATA_W-CFG_W){1'b0}}, nps_reg} : '0;
    assign num_period_samples = nps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nps_reg <= NPS_RESET;
        end
        else if (psel && penable && pwrite && hit)
        begin
            nps_reg <= pwdata[CFG_W-1:0];
        end
    end
endmodule

[rtl/zcpm_div.sv]
// ----------------------------------------------------------------------------
// zcpm_div
// Restoring divider producing the crossing fraction one bit per cycle.
// ----------------------------------------------------------------------------
module zcpm_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [zcpm_pkg::SAMPLE_W-1:0] num_hi,
    input  logic [zcpm_pkg::DEN_W-1:0]    den,
    output logic [zcpm_pkg::QUO_W-1:0]    quot,
    output logic                          done
);
    import zcpm_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);

    logic [REM_W-1:0] rem_reg;
    logic [QUO_W-1:0] quot_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             ge;
    logic [REM_W-1:0] rem_sub;

    assign ge      = (rem_reg >= {1'b0, den_reg});
    assign rem_sub = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;
    assign quot    = quot_reg;
    assign done    = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(QUO_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= {{(REM_W-SAMPLE_W){1'b0}}, num_hi};
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= {rem_sub[REM_W-2:0], 1'b0};
            quot_reg <= {quot_reg[QUO_W-2:0], ge};
        end
    end
endmodule

[rtl/zcpm_win.sv]
// ----------------------------------------------------------------------------
// zcpm_win
// Window of recent periods and a sequential stability checker.
// ----------------------------------------------------------------------------
module zcpm_win #(
    parameter int STABLE_WINDOW = zcpm_pkg::STABLE_WINDOW_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  zcpm_pkg::win_ctrl_t           ctrl,
    input  logic [zcpm_pkg::PERIOD_W-1:0] period,
    output zcpm_pkg::win_stat_t           stat
);
    import zcpm_pkg::*;

    localparam int IDX_W = $clog2(STABLE_WINDOW);
    localparam int SUM_W = PERIOD_W + $clog2(STABLE_WINDOW);
    localparam int TEN_W = SUM_W + 4;
    localparam logic [SUM_W-1:0] W_C = SUM_W'(STABLE_WINDOW);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STABLE_WINDOW - 1);

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_SUM  = 2'd1;
    localparam logic [1:0] P_DEV  = 2'd2;
    localparam logic [1:0] P_CMP  = 2'd3;

    logic [PERIOD_W-1:0] recent_reg [STABLE_WINDOW];
    logic [1:0]          phase_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    dev_reg;
    logic                done_reg;
    logic                stable_reg;
    logic [SUM_W-1:0]    cur;
    logic [SUM_W-1:0]    scaled;
    logic [SUM_W-1:0]    dev;
    logic [TEN_W-1:0]    ten_dev;

    assign cur     = SUM_W'(recent_reg[idx_reg]);
    assign scaled  = cur * W_C;
    assign dev     = (scaled >= sum_reg) ? (scaled - sum_reg) : (sum_reg - scaled);
    assign ten_dev = {dev_reg, 3'b000} + {2'b00, dev_reg, 1'b0};

    assign stat.done   = done_reg;
    assign stat.stable = stable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STABLE_WINDOW; i++)
            begin
                recent_reg[i] <= '0;
            end
        end
        else if (ctrl.clear)
        begin
            for (int i = 0; i < STABLE_WINDOW; i++)
            begin
                recent_reg[i] <= '0;
            end
        end
        else if (ctrl.push)
        begin
            for (int i = 0; i < STABLE_WINDOW - 1; i++)
            begin
                recent_reg[i] <= recent_reg[i+1];
            end
            recent_reg[STABLE_WINDOW-1] <= period;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= P_IDLE;
            idx_reg    <= '0;
            done_reg   <= 1'b0;
            stable_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (phase_reg)
                P_IDLE:
                begin
                    if (ctrl.check)
                    begin
                        phase_reg <= P_SUM;
                        idx_reg   <= '0;
                    end
                end
                P_SUM:
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        idx_reg   <= '0;
                        phase_reg <= P_DEV;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                P_DEV:
                begin
                    phase_reg <= P_CMP;
                end
                P_CMP:
                begin
                    if (ten_dev >= TEN_W'(sum_reg))
                    begin
                        stable_reg <= 1'b0;
                        done_reg   <= 1'b1;
                        phase_reg  <= P_IDLE;
                    end
                    else if (idx_reg == LAST_IDX)
                    begin
                        stable_reg <= 1'b1;
                        done_reg   <= 1'b1;
                        phase_reg  <= P_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        phase_reg <= P_DEV;
                    end
                end
                default:
                begin
                    phase_reg <= P_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == P_IDLE && ctrl.check)
        begin
            sum_reg <= '0;
        end
        else if (phase_reg == P_SUM)
        begin
            sum_reg <= sum_reg + cur;
        end
        if (phase_reg == P_DEV)
        begin
            dev_reg <= dev;
        end
    end
endmodule

[rtl/zero_crossing_period_meter_unit.sv]
// ----------------------------------------------------------------------------
// zero_crossing_period_meter_unit
// Measures signal period from interpolated rising zero crossings.
// ----------------------------------------------------------------------------
// Each beat on in_ch is an audio sample, a start request or a stop request.
// Every accepted beat yields exactly one beat on out_ch with the crossing
// flag, the period in samples with 16 fraction bits, and the measurement
// status, count and saturating total.
// A start, a stop, the unused code or an ignored sample goes straight to the
// result. A measured sample without a crossing passes the update and finish
// steps first. A crossing runs the divider, one quotient bit per cycle, then
// forms the position and the period, adds the period to the total while
// stable, and passes the update and finish steps. While settling with more
// than STABLE_WINDOW stored periods, the update step also starts the
// stability checker, which sums the window, tests each deviation in turn,
// stops at the first that fails and hands its verdict back. The next beat
// is accepted in the cycle after the result leaves.
// One beat is in work at a time: in_ch.ready is high only while the unit
// waits for a beat, and the result is held until out_ch takes it.
// Reset clears the state and sets num_period_samples to 10; the APB port
// writes it, and the user must do so only while the unit is idle, which
// the unit itself does not enforce.
// ----------------------------------------------------------------------------
module zero_crossing_period_meter_unit #(
    parameter int MAX_PERIODS   = zcpm_pkg::MAX_PERIODS_DEF,
    parameter int STABLE_WINDOW = zcpm_pkg::STABLE_WINDOW_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    zcpm_in_if.sink                         in_ch,
    zcpm_out_if.source                      out_ch,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [zcpm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [zcpm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [zcpm_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import zcpm_pkg::*;

    localparam int STORE_W = $clog2(MAX_PERIODS + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIV  = 4'd1;
    localparam logic [3:0] S_POS  = 4'd2;
    localparam logic [3:0] S_PER  = 4'd3;
    localparam logic [3:0] S_ACC  = 4'd4;
    localparam logic [3:0] S_UPD  = 4'd5;
    localparam logic [3:0] S_CHK  = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0]                 state_reg, state_next;
    logic signed [SAMPLE_W-1:0] smp_reg, smp_next;
    logic signed [SAMPLE_W-1:0] prev_sample_reg, prev_sample_next;
    logic [INDEX_W-1:0]         index_reg, index_next;
    logic signed [POS_W-1:0]    prev_pos_reg, prev_pos_next;
    logic signed [POS_W-1:0]    pos_reg, pos_next;
    logic [STORE_W-1:0]         stored_reg, stored_next;
    logic [STATUS_W-1:0]        status_reg, status_next;
    logic [TOTAL_W-1:0]         total_reg, total_next;
    logic [COUNT_W-1:0]         vcount_reg, vcount_next;
    logic                       crossing_reg, crossing_next;
    logic [PERIOD_W-1:0]        period_reg, period_next;
    logic                       counts_reg, counts_next;

    logic [CFG_W-1:0]           nps;
    logic                       accept;
    logic                       measuring;
    logic                       div_start;
    logic [SAMPLE_W-1:0]        div_num;
    logic [DEN_W-1:0]           div_den;
    logic [QUO_W-1:0]           div_quot;
    logic                       div_done;
    win_ctrl_t                  win_ctrl;
    win_stat_t                  win_stat;
    logic signed [INDEX_W:0]    idxm1;
    logic signed [POS_W:0]      diff;
    logic [PERIOD_W-1:0]        per_val;
    logic [TOTAL_W:0]           total_sum;

    zcpm_cfg u_cfg (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .num_period_samples (nps)
    );

    zcpm_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num_hi (div_num),
        .den    (div_den),
        .quot   (div_quot),
        .done   (div_done)
    );

    zcpm_win #(
        .STABLE_WINDOW (STABLE_WINDOW)
    ) u_win (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (win_ctrl),
        .period (per_val),
        .stat   (win_stat)
    );

    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign measuring   = (status_reg == ST_SETTLING) || (status_reg == ST_STABLE);

    assign div_num = (~prev_sample_reg) + 1'b1;
    assign div_den = {in_ch.sample[SAMPLE_W-1], in_ch.sample}
                     - {prev_sample_reg[SAMPLE_W-1], prev_sample_reg};

    assign idxm1 = $signed({1'b0, index_reg}) - $signed((INDEX_W+1)'(1));
    assign diff  = $signed({pos_reg[POS_W-1], pos_reg})
                   - $signed({prev_pos_reg[POS_W-1], prev_pos_reg});
    assign per_val   = diff[POS_W] ? '0 : diff[PERIOD_W-1:0];
    assign total_sum = {1'b0, total_reg} + (TOTAL_W+1)'(period_reg);

    assign out_ch.valid         = (state_reg == S_OUT);
    assign out_ch.crossing      = crossing_reg;
    assign out_ch.period        = period_reg;
    assign out_ch.period_counts = counts_reg;
    assign out_ch.status        = status_reg;
    assign out_ch.valid_count   = vcount_reg;
    assign out_ch.period_total  = total_reg;

    always_comb
    begin
        state_next       = state_reg;
        smp_next         = smp_reg;
        prev_sample_next = prev_sample_reg;
        index_next       = index_reg;
        prev_pos_next    = prev_pos_reg;
        pos_next         = pos_reg;
        stored_next      = stored_reg;
        status_next      = status_reg;
        total_next       = total_reg;
        vcount_next      = vcount_reg;
        crossing_next    = crossing_reg;
        period_next      = period_reg;
        counts_next      = counts_reg;
        div_start        = 1'b0;
        win_ctrl         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    smp_next      = in_ch.sample;
                    crossing_next = 1'b0;
                    period_next   = '0;
                    counts_next   = 1'b0;
                    state_next    = S_OUT;
                    case (in_ch.req_type)
                        REQ_START:
                        begin
                            index_next     = '0;
                            prev_pos_next  = POS_START;
                            stored_next    = '0;
                            total_next     = '0;
                            vcount_next    = '0;
                            status_next    = ST_SETTLING;
                            win_ctrl.clear = 1'b1;
                        end
                        REQ_STOP:
                        begin
                            status_next = ST_IDLE;
                        end
                        REQ_SAMPLE:
                        begin
                            if (measuring)
                            begin
                                if (prev_sample_reg[SAMPLE_W-1] && !in_ch.sample[SAMPLE_W-1]
                                    && (32'(stored_reg) < 32'(MAX_PERIODS)))
                                begin
                                    div_start  = 1'b1;
                                    state_next = S_DIV;
                                end
                                else
                                begin
                                    state_next = S_UPD;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_POS;
                end
            end
            S_POS:
            begin
                pos_next   = $signed({idxm1, {FRAC_W{1'b0}}})
                             + $signed({{(POS_W-QUO_W){1'b0}}, div_quot});
                state_next = S_PER;
            end
            S_PER:
            begin
                period_next   = per_val;
                crossing_next = 1'b1;
                win_ctrl.push = 1'b1;
                stored_next   = stored_reg + 1'b1;
                prev_pos_next = pos_reg;
                if (status_reg == ST_STABLE)
                begin
                    vcount_next = vcount_reg + 1'b1;
                    counts_next = 1'b1;
                    state_next  = S_ACC;
                end
                else
                begin
                    state_next = S_UPD;
                end
            end
            S_ACC:
            begin
                total_next = total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];
                state_next = S_UPD;
            end
            S_UPD:
            begin
                prev_sample_next = smp_reg;
                if (index_reg != {INDEX_W{1'b1}})
                begin
                    index_next = index_reg + 1'b1;
                end
                if ((status_reg == ST_SETTLING)
                    && (32'(stored_reg) > 32'(STABLE_WINDOW)))
                begin
                    win_ctrl.check = 1'b1;
                    state_next     = S_CHK;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_CHK:
            begin
                if (win_stat.done)
                begin
                    if (win_stat.stable)
                    begin
                        status_next = ST_STABLE;
                    end
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if ((status_reg == ST_STABLE) && (vcount_reg > {1'b0, nps}))
                begin
                    status_next = ST_DONE;
                end
                else if ((status_reg != ST_STABLE)
                         && (32'(stored_reg) >= 32'(MAX_PERIODS)))
                begin
                    status_next = ST_FAILED;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ch.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            prev_sample_reg <= '0;
            index_reg       <= '0;
            prev_pos_reg    <= POS_START;
            stored_reg      <= '0;
            status_reg      <= ST_IDLE;
            total_reg       <= '0;
            vcount_reg      <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            prev_sample_reg <= prev_sample_next;
            index_reg       <= index_next;
            prev_pos_reg    <= prev_pos_next;
            stored_reg      <= stored_next;
            status_reg      <= status_next;
            total_reg       <= total_next;
            vcount_reg      <= vcount_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg      <= smp_next;
        pos_reg      <= pos_next;
        crossing_reg <= crossing_next;
        period_reg   <= period_next;
        counts_reg   <= counts_next;
    end
endmodule

[tb/sv/zcpm_meter_compare.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zcpm_meter_compare
// Predicts and checks every result beat of the zero crossing period meter.
// ----------------------------------------------------------------------------
// The module watches the request channel, the result channel and register
// writes on the APB port. Each accepted request beat runs through a cycle-free
// model of the meter: crossing interpolation, the period window with its
// stability test, the saturating total and the status sequence. The result
// it predicts is queued and compared field by field with the next result beat
// that the unit hands over. Mismatches and the number of results still due
// are reported to the testbench top.
// ----------------------------------------------------------------------------
module zcpm_meter_compare (
    input  logic                            clk,
    input  logic                            rst_n,
    zcpm_in_if                              in_ch,
    zcpm_out_if                             out_ch,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [zcpm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [zcpm_pkg::APB_DATA_W-1:0] pwdata,
    input  logic                            pready,
    output int                              mismatches,
    output int                              beats_due
);
    import zcpm_pkg::*;

    localparam int WIN = STABLE_WINDOW_DEF;
    localparam int MAXP = MAX_PERIODS_DEF;
    localparam longint ONE_FIX = longint'(1) << FRAC_W;
    localparam logic [63:0] PERIOD_MASK = (64'd1 << PERIOD_W) - 64'd1;
    localparam logic [63:0] TOTAL_MASK = (64'd1 << TOTAL_W) - 64'd1;
    localparam logic [APB_ADDR_W-1:0] NPS_ADDR = {REG_NPS, 2'b00};

    typedef struct packed {
        logic                crossing;
        logic [PERIOD_W-1:0] period;
        logic                counts;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
        logic [TOTAL_W-1:0]  total;
    } meter_result_t;

    logic [CFG_W-1:0]           nps;
    logic signed [SAMPLE_W-1:0] last_smp;
    logic [INDEX_W-1:0]         idx;
    longint                     xing_pos;
    logic [63:0]                win [WIN];
    int                         stored;
    bit                         locked;
    logic [STATUS_W-1:0]        meter_st;
    logic [63:0]                total;
    int                         counted;
    meter_result_t              results_due [$];

    function automatic void restart_meter();
        idx = '0;
        xing_pos = -ONE_FIX;
        foreach (win[i])
            win[i] = '0;
        stored = 0;
        locked = 1'b0;
        total = '0;
        counted = 0;
    endfunction

    function automatic bit window_settled();
        logic [63:0] sum;
        logic [63:0] scaled;
        logic [63:0] dev;
        sum = '0;
        foreach (win[i])
            sum += win[i];
        foreach (win[i])
        begin
            scaled = win[i] * 64'(WIN);
            dev = (scaled >= sum) ? scaled - sum : sum - scaled;
            if (dev * 64'd10 >= sum)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic meter_result_t step_meter(input logic [REQ_W-1:0] rq,
                                                 input logic signed [SAMPLE_W-1:0] smp);
        meter_result_t r;
        longint        num;
        longint        den;
        longint        pos;
        longint        diff;
        logic [63:0]   p;
        r = '0;
        case (rq)
            REQ_START:
            begin
                restart_meter();
                meter_st = ST_SETTLING;
            end
            REQ_STOP:
                meter_st = ST_IDLE;
            REQ_SAMPLE:
            begin
                if (meter_st == ST_SETTLING || meter_st == ST_STABLE)
                begin
                    if (last_smp < 0 && smp >= 0 && stored < MAXP)
                    begin
                        num = -longint'(last_smp) * ONE_FIX;
                        den = longint'(smp) - longint'(last_smp);
                        pos = (longint'(idx) - 1) * ONE_FIX + num / den;
                        diff = pos - xing_pos;
                        p = (diff < 0) ? 64'd0 : (64'(diff) & PERIOD_MASK);
                        for (int i = 0; i < WIN - 1; i++)
                            win[i] = win[i + 1];
                        win[WIN - 1] = p;
                        stored++;
                        xing_pos = pos;
                        r.crossing = 1'b1;
                        r.period = p[PERIOD_W-1:0];
                        if (locked)
                        begin
                            counted++;
                            total = (TOTAL_MASK - total < p) ? TOTAL_MASK : total + p;
                            r.counts = 1'b1;
                        end
                    end
                    last_smp = smp;
                    if (idx != '1)
                        idx++;
                    if (!locked && stored > WIN && window_settled())
                    begin
                        locked = 1'b1;
                        meter_st = ST_STABLE;
                    end
                    if (locked && counted > int'(nps))
                        meter_st = ST_DONE;
                    else if (!locked && stored >= MAXP)
                        meter_st = ST_FAILED;
                end
            end
            default:
                ;
        endcase
        r.status = meter_st;
        r.count = counted[COUNT_W-1:0];
        r.total = total[TOTAL_W-1:0];
        return r;
    endfunction

    function automatic void compare_field(input string field, input logic [63:0] want,
                                          input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
        end
    endfunction

    initial mismatches = 0;

    always @(posedge clk or negedge rst_n)
    begin
        meter_result_t want;
        if (!rst_n)
        begin
            nps = NPS_RESET;
            last_smp = '0;
            meter_st = ST_IDLE;
            restart_meter();
            results_due.delete();
            beats_due <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == NPS_ADDR)
                nps = pwdata[CFG_W-1:0];
            if (in_ch.valid && in_ch.ready)
                results_due.push_back(step_meter(in_ch.req_type, in_ch.sample));
            if (out_ch.valid && out_ch.ready)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result beat with no request beat pending");
                    mismatches++;
                end
                else
                begin
                    want = results_due.pop_front();
                    compare_field("crossing", 64'(want.crossing), 64'(out_ch.crossing));
                    compare_field("period", 64'(want.period), 64'(out_ch.period));
                    compare_field("period_counts", 64'(want.counts),
                                  64'(out_ch.period_counts));
                    compare_field("status", 64'(want.status), 64'(out_ch.status));
                    compare_field("valid_count", 64'(want.count), 64'(out_ch.valid_count));
                    compare_field("period_total", 64'(want.total),
                                  64'(out_ch.period_total));
                end
            end
            beats_due <= results_due.size();
        end
    end

endmodule

[tb/sv/zero_crossing_period_meter_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zero_crossing_period_meter_unit_tb
// Stimulus and verdict for the zero crossing period meter.
// ----------------------------------------------------------------------------
// After reset a short directed run covers ignored samples, the unused request
// code, stop and restart, and the sample extremes at a crossing. Then come
// measurements built from periodic waves with random content: clean ones that
// settle and finish, a long one that fills the period store while stable, an
// alternating one that fails as not stable, jittered ones and random noise.
// num_period_samples is rewritten between measurements, 1 and 255 among
// them. Both channels idle at random, and once the result side holds off for
// a long stretch. zcpm_meter_compare predicts and checks every result beat.
// ----------------------------------------------------------------------------
module zero_crossing_period_meter_unit_tb;
    import zcpm_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam logic [APB_ADDR_W-1:0] NPS_ADDR = {REG_NPS, 2'b00};

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    mismatches;
    int                    beats_due;
    int                    beats_sent;
    logic [CFG_W-1:0]      nps_now;
    bit                    calm;
    bit                    squeeze;

    zcpm_in_if  in_ch ();
    zcpm_out_if out_ch ();

    zero_crossing_period_meter_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    zcpm_meter_compare u_compare (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .mismatches (mismatches),
        .beats_due  (beats_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (squeeze)
            begin
                squeeze = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            out_ch.ready <= calm || ($urandom_range(99) >= 8);
        end
    end

    task automatic send_beat(input logic [REQ_W-1:0] rq, input logic signed [SAMPLE_W-1:0] smp);
        if (!calm)
        begin
            while ($urandom_range(99) < 8)
            begin
                in_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_ch.valid <= 1'b1;
        in_ch.req_type <= rq;
        in_ch.sample <= smp;
        do
            @(posedge clk);
        while (!in_ch.ready);
        beats_sent++;
    endtask

    task automatic await_idle();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (beats_due != 0);
    endtask

    task automatic write_nps(input logic [CFG_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= NPS_ADDR;
        pwdata <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        nps_now = value;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_low();
        return SAMPLE_W'(-1 - int'($urandom_range(32767)));
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_high();
        return SAMPLE_W'($urandom_range(32767));
    endfunction

    // Each period opens with its non-negative half; the step from the last
    // negative sample to the next period's first sample is the crossing.
    task automatic play_wave(input int periods, input int len_a, input int len_b,
                             input bit fixed_edge, input logic signed [SAMPLE_W-1:0] lo,
                             input logic signed [SAMPLE_W-1:0] hi);
        int                         span;
        logic signed [SAMPLE_W-1:0] smp;
        for (int k = 0; k < periods; k++)
        begin
            span = (k % 2 == 0) ? len_a : len_b;
            for (int i = 0; i < span; i++)
            begin
                if (i == 0)
                    smp = fixed_edge ? hi : rand_high();
                else if (i == span - 1)
                    smp = fixed_edge ? lo : rand_low();
                else if (i < span / 2)
                    smp = rand_high();
                else
                    smp = rand_low();
                send_beat(REQ_SAMPLE, smp);
            end
        end
    endtask

    task automatic measure_stable(input int len);
        logic signed [SAMPLE_W-1:0] lo;
        logic signed [SAMPLE_W-1:0] hi;
        lo = rand_low();
        hi = rand_high();
        send_beat(REQ_START, SAMPLE_W'($urandom));
        play_wave(8 + int'(nps_now) + $urandom_range(3), len, len, 1'b1, lo, hi);
        if ($urandom_range(1) == 1)
            send_beat(REQ_STOP, SAMPLE_W'($urandom));
    endtask

    initial
    begin
        int pick;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_ch.valid <= 1'b0;
        in_ch.req_type <= REQ_SAMPLE;
        in_ch.sample <= '0;
        beats_sent = 0;
        nps_now = NPS_RESET;
        calm = 1'b0;
        squeeze = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(REQ_SAMPLE, 16'sh7FFF);
        send_beat(REQ_SAMPLE, 16'sh8000);
        send_beat(REQ_UNUSED, 16'sh5A5A);
        send_beat(REQ_STOP, 16'sh0000);
        send_beat(REQ_START, 16'sh0000);
        send_beat(REQ_SAMPLE, 16'sh8000);
        send_beat(REQ_SAMPLE, 16'sh7FFF);
        send_beat(REQ_SAMPLE, -16'sd1);
        send_beat(REQ_SAMPLE, 16'sh0000);
        send_beat(REQ_SAMPLE, 16'sh8000);
        send_beat(REQ_SAMPLE, 16'sh0000);
        send_beat(REQ_SAMPLE, -16'sd1);
        send_beat(REQ_SAMPLE, 16'sh7FFF);
        send_beat(REQ_SAMPLE, 16'sh0000);
        send_beat(REQ_SAMPLE, 16'sh0000);
        send_beat(REQ_SAMPLE, 16'sd5);
        send_beat(REQ_SAMPLE, -16'sd7);
        send_beat(REQ_UNUSED, 16'sh1234);
        send_beat(REQ_START, 16'shFFFF);
        send_beat(REQ_SAMPLE, 16'sd3);
        send_beat(REQ_STOP, 16'sh0000);
        send_beat(REQ_SAMPLE, -16'sd5);
        send_beat(REQ_SAMPLE, 16'sd9);
        await_idle();

        write_nps(8'd1);
        measure_stable($urandom_range(2, 6));
        measure_stable($urandom_range(2, 6));
        await_idle();

        // Runs past the store size while stable, so late crossings go unrecorded.
        write_nps(8'd255);
        calm = 1'b1;
        send_beat(REQ_START, SAMPLE_W'($urandom));
        play_wave(262, 2, 2, 1'b1, rand_low(), rand_high());
        send_beat(REQ_STOP, SAMPLE_W'($urandom));
        calm = 1'b0;
        await_idle();

        // Alternating periods never settle, so the store fills and the run fails.
        write_nps(8'($urandom_range(1, 12)));
        send_beat(REQ_START, SAMPLE_W'($urandom));
        play_wave(120, 2, 3, 1'b1, rand_low(), rand_high());
        squeeze = 1'b1;
        play_wave(140, 2, 3, 1'b1, rand_low(), rand_high());
        send_beat(REQ_SAMPLE, rand_low());
        send_beat(REQ_SAMPLE, rand_high());

        while (beats_sent < 1320)
        begin
            pick = $urandom_range(9);
            if (pick < 5)
            begin
                if ($urandom_range(2) == 0)
                begin
                    await_idle();
                    write_nps(8'($urandom_range(1, 12)));
                end
                measure_stable($urandom_range(2, 6));
            end
            else if (pick < 8)
            begin
                send_beat(REQ_START, SAMPLE_W'($urandom));
                play_wave($urandom_range(4, 24), $urandom_range(2, 6), $urandom_range(2, 6),
                          1'b0, '0, '0);
                if ($urandom_range(1) == 1)
                    send_beat(REQ_STOP, SAMPLE_W'($urandom));
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_beat(REQ_W'($urandom_range(3)), SAMPLE_W'($urandom));
            end
        end

        await_idle();
        write_nps(NPS_RESET);
        measure_stable(2);
        await_idle();
        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
